FILE: rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication or property on every clock edge outside reset.
`define SSTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next.
`define SSTF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sstf_pkg.sv
// Types and constants shared by the shortest-seek-first scheduler.
package sstf_pkg;

    localparam int TRACK_BITS        = 16;
    localparam int TOTAL_W           = 22;
    localparam int QUEUE_DEPTH_DEF   = 32;

    localparam logic [TRACK_BITS-1:0] START_RESET = TRACK_BITS'(15);
    localparam logic [TOTAL_W-1:0]    TOTAL_MAX   = {TOTAL_W{1'b1}};

    typedef struct packed {
        logic [TRACK_BITS-1:0] track;
        logic                  final_req;
    } t_in_item;

    typedef struct packed {
        logic [TRACK_BITS-1:0] from_track;
        logic [TRACK_BITS-1:0] to_track;
        logic [TRACK_BITS-1:0] distance;
        logic [TOTAL_W-1:0]    running_total;
        logic                  dropped;
        logic                  last_seek;
    } t_out_item;

    // Controls driven from the sequencer into one cell.
    typedef struct packed {
        logic                  load;
        logic                  calc;
        logic                  take;
        logic                  flush;
        logic [TRACK_BITS-1:0] track;
        logic [TRACK_BITS-1:0] head;
    } t_cell_ctl;

    // Best candidate seen so far, handed from cell to cell.
    typedef struct packed {
        logic                  found;
        logic [TRACK_BITS-1:0] span;
        logic [TRACK_BITS-1:0] track;
    } t_token;

endpackage

FILE: rtl/sstf_cell.sv
// One request slot of the scheduler's compare chain.
module sstf_cell
    import sstf_pkg::*;
#(
    parameter int IDX_W   = 5,
    parameter int CELL_ID = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  t_token           i_tok,
    input  logic [IDX_W-1:0] i_idx,
    output t_token           o_tok,
    output logic [IDX_W-1:0] o_idx
);

    logic [TRACK_BITS-1:0] r_track;
    logic [TRACK_BITS-1:0] r_dist;
    logic                  r_pend;
    t_token                r_tok;
    logic [IDX_W-1:0]      r_idx;
    logic                  w_mine;

    // A strictly smaller distance replaces the incoming candidate, so ties
    // stay with the earlier slot.
    assign w_mine = r_pend && (!i_tok.found || (r_dist < i_tok.span));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
            r_tok  <= '0;
        end else begin
            if (i_ctl.load) begin
                r_pend <= 1'b1;
            end else if (i_ctl.take || i_ctl.flush) begin
                r_pend <= 1'b0;
            end
            if (w_mine) begin
                r_tok <= '{found: 1'b1, span: r_dist, track: r_track};
            end else begin
                r_tok <= i_tok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_track <= i_ctl.track;
        end
        if (i_ctl.calc) begin
            r_dist <= (i_ctl.head >= r_track) ? (i_ctl.head - r_track)
                                              : (r_track - i_ctl.head);
        end
        r_idx <= w_mine ? IDX_W'(CELL_ID) : i_idx;
    end

    assign o_tok = r_tok;
    assign o_idx = r_idx;

endmodule

FILE: rtl/shortest_seek_first_scheduler.sv
// Shortest-seek-first disk request scheduler, top level.
//
// Usage: requests arrive on the input channel (i_in_valid, o_in_stall,
// i_in_data), one track per transaction, and are stored in order in a row of
// QUEUE_DEPTH cells, one request per cycle while o_in_stall is low. A request
// that finds the table full is dropped and flags every result of its batch.
// The transaction with final_req set closes the batch; o_in_stall then stays
// high until the last result of the batch has been loaded into the output
// register. Service starts at start_track, written on the configuration
// channel (i_cfg_valid, o_cfg_ready, i_cfg_data); the user is to write it only
// while the block is idle, as the block itself does not enforce this. Each
// pick computes every cell's distance to the head, then lets the best
// candidate travel the chain of cells, then issues the result; the picks of
// a batch run one after another.
// Results leave through a register on the output channel (o_out_valid,
// i_out_stall, o_out_data); while the receiver stalls, the held result stays
// put and the next pick waits in its issue cycle.
// Reset clears the table, the running total and the drop flag, and sets
// start_track to 15.
module shortest_seek_first_scheduler
    import sstf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [TRACK_BITS-1:0] i_cfg_data
);

    localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int STEP_W = IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIST,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state                r_state;
    logic [TRACK_BITS-1:0] r_start_track;
    logic [TRACK_BITS-1:0] r_head;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      r_served;
    logic [TOTAL_W-1:0]    r_total;
    logic                  r_ovf;
    logic [STEP_W-1:0]     r_step;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_in_fire;
    logic                  w_emit_fire;
    logic                  w_last;
    logic [CNT_W-1:0]      n_served;
    logic [TOTAL_W:0]      n_sum;
    logic [TOTAL_W-1:0]    n_total;

    t_cell_ctl             w_ctl [QUEUE_DEPTH];
    t_token                w_tok [QUEUE_DEPTH];
    logic [IDX_W-1:0]      w_idx [QUEUE_DEPTH];
    t_token                w_best;
    logic [IDX_W-1:0]      w_best_idx;

    assign w_best     = w_tok[QUEUE_DEPTH-1];
    assign w_best_idx = w_idx[QUEUE_DEPTH-1];

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign w_emit_fire = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign n_served    = r_served + CNT_W'(1);
    assign w_last      = (n_served == r_count);
    assign n_sum       = {1'b0, r_total} + (TOTAL_W + 1)'(w_best.span);
    assign n_total     = (n_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : n_sum[TOTAL_W-1:0];

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            always_comb begin
                w_ctl[gi].load  = w_in_fire && (r_count == CNT_W'(gi));
                w_ctl[gi].calc  = (r_state == S_DIST);
                w_ctl[gi].take  = w_emit_fire && (w_best_idx == IDX_W'(gi));
                w_ctl[gi].flush = w_emit_fire && w_last;
                w_ctl[gi].track = i_in_data.track;
                w_ctl[gi].head  = r_head;
            end

            if (gi == 0) begin : g_first
                sstf_cell #(
                    .IDX_W   (IDX_W),
                    .CELL_ID (gi)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (w_ctl[gi]),
                    .i_tok   ('0),
                    .i_idx   ('0),
                    .o_tok   (w_tok[gi]),
                    .o_idx   (w_idx[gi])
                );
            end else begin : g_rest
                sstf_cell #(
                    .IDX_W   (IDX_W),
                    .CELL_ID (gi)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctl   (w_ctl[gi]),
                    .i_tok   (w_tok[gi-1]),
                    .i_idx   (w_idx[gi-1]),
                    .o_tok   (w_tok[gi]),
                    .o_idx   (w_idx[gi])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_start_track <= START_RESET;
            r_head        <= START_RESET;
            r_count       <= '0;
            r_served      <= '0;
            r_total       <= '0;
            r_ovf         <= 1'b0;
            r_step        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_start_track <= i_cfg_data;
            end
            if (w_emit_fire) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_fire) begin
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_count <= r_count + CNT_W'(1);
                        end
                        if (i_in_data.final_req) begin
                            r_head   <= r_start_track;
                            r_served <= '0;
                            r_state  <= S_DIST;
                        end
                    end
                end
                S_DIST: begin
                    r_step  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // The candidate leaves the last cell once it has passed
                    // every slot of the chain.
                    if (r_step == STEP_W'(QUEUE_DEPTH - 1)) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_step <= r_step + STEP_W'(1);
                    end
                end
                S_EMIT: begin
                    if (w_emit_fire) begin
                        r_out       <= '{from_track:    r_head,
                                         to_track:      w_best.track,
                                         distance:      w_best.span,
                                         running_total: n_total,
                                         dropped:       r_ovf,
                                         last_seek:     w_last};
                        r_head      <= w_best.track;
                        r_served    <= n_served;
                        if (w_last) begin
                            r_count <= '0;
                            r_total <= '0;
                            r_ovf   <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_total <= n_total;
                            r_state <= S_DIST;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`include "assert_macros.svh"

    `SSTF_ASSERT(a_count_bound, r_count <= CNT_W'(QUEUE_DEPTH), "request count beyond table depth")
    `SSTF_ASSERT(a_pick_found, w_emit_fire |-> w_best.found, "result issued with no pending request")
    `SSTF_ASSERT(a_scan_open, (r_state == S_SCAN) |-> (r_served < r_count), "scan with nothing left to serve")
    `SSTF_ASSERT_NEXT(a_batch_end, w_emit_fire && w_last, (r_count == '0) && (r_state == S_IDLE), "batch not cleared after last seek")

endmodule

FILE: tb/shortest_seek_first_scheduler_tb.sv
// Self-checking testbench for the shortest-seek-first disk request scheduler.
module shortest_seek_first_scheduler_tb;
    import sstf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = QUEUE_DEPTH_DEF;
    localparam int PICK_CYCLES = TABLE_DEPTH + 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int ITEM_TARGET = 270;
    localparam int REPORT_LIMIT = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [TRACK_BITS-1:0] i_cfg_data = '0;

    // Scheduler state as the testbench sees it.
    logic [TRACK_BITS-1:0] start_track_reg = START_RESET;
    logic [TRACK_BITS-1:0] loaded_tracks[$];
    logic                  batch_dropped = 1'b0;
    t_out_item             expected_seeks[$];

    int mismatch_count = 0;
    int requests_sent = 0;
    int seeks_checked = 0;
    int batches_closed = 0;
    int dropped_batches = 0;
    int start_writes = 0;
    int cycle_count = 0;
    int burst_left = 8;
    int hold_request = 0;
    logic [TRACK_BITS-1:0] cluster_base = '0;

    shortest_seek_first_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d seeks still outstanding",
                     cycle_count, expected_seeks.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic logic [TRACK_BITS-1:0] seek_gap(logic [TRACK_BITS-1:0] a,
                                                       logic [TRACK_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Serves the loaded batch nearest-first and queues the seeks it produces.
    function automatic void serve_batch();
        logic [TRACK_BITS-1:0] head;
        logic [TRACK_BITS-1:0] best_gap;
        logic [TRACK_BITS-1:0] d;
        logic [TOTAL_W-1:0]    total;
        logic [TOTAL_W:0]      sum;
        int                    best;
        t_out_item             seek;
        head = start_track_reg;
        total = '0;
        while (loaded_tracks.size() > 0) begin
            best = 0;
            best_gap = seek_gap(head, loaded_tracks[0]);
            // Strict compare keeps the earliest-loaded request on a tie.
            for (int i = 1; i < loaded_tracks.size(); i++) begin
                d = seek_gap(head, loaded_tracks[i]);
                if (d < best_gap) begin
                    best = i;
                    best_gap = d;
                end
            end
            sum = {1'b0, total} + (TOTAL_W + 1)'(best_gap);
            total = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[TOTAL_W-1:0];
            seek.from_track = head;
            seek.to_track = loaded_tracks[best];
            seek.distance = best_gap;
            seek.running_total = total;
            seek.dropped = batch_dropped;
            seek.last_seek = (loaded_tracks.size() == 1);
            expected_seeks = {expected_seeks, seek};
            head = loaded_tracks[best];
            loaded_tracks.delete(best);
        end
        if (batch_dropped)
            dropped_batches++;
        batch_dropped = 1'b0;
        batches_closed++;
    endfunction

    function automatic void accept_request(t_in_item item);
        if (loaded_tracks.size() < TABLE_DEPTH)
            loaded_tracks = {loaded_tracks, item.track};
        else
            batch_dropped = 1'b1;
        if (item.final_req)
            serve_batch();
    endfunction

    function automatic logic [TRACK_BITS-1:0] pick_track();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return cluster_base + TRACK_BITS'($urandom_range(0, 3));
            default: return TRACK_BITS'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seeks_checked++;
            if (expected_seeks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("unexpected seek: from %0d to %0d dist %0d total %0d",
                             o_out_data.from_track, o_out_data.to_track,
                             o_out_data.distance, o_out_data.running_total);
            end else begin
                want = expected_seeks.pop_front();
                if (o_out_data.from_track !== want.from_track ||
                    o_out_data.to_track !== want.to_track ||
                    o_out_data.distance !== want.distance ||
                    o_out_data.running_total !== want.running_total ||
                    o_out_data.dropped !== want.dropped ||
                    o_out_data.last_seek !== want.last_seek) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("seek mismatch at cycle %0d", cycle_count);
                        $display("  expected from %0d to %0d dist %0d total %0d drop %0b last %0b",
                                 want.from_track, want.to_track, want.distance,
                                 want.running_total, want.dropped, want.last_seek);
                        $display("  actual   from %0d to %0d dist %0d total %0d drop %0b last %0b",
                                 o_out_data.from_track, o_out_data.to_track,
                                 o_out_data.distance, o_out_data.running_total,
                                 o_out_data.dropped, o_out_data.last_seek);
                    end
                end
            end
        end
    end

    // Output stall pattern: changes mode now and then, with a long hold-off on request.
    always @(negedge i_clk) begin
        static int mode_left = 0;
        static int stall_mode = 0;
        static int hold_left = 0;
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 120);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 3) == 0);
                2: i_out_stall <= ($urandom_range(0, 9) < 7);
                default: i_out_stall <= mode_left[2];
            endcase
        end
    end

    task automatic pause_input(int cycles);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    task automatic send_request(logic [TRACK_BITS-1:0] trk, logic fin);
        t_in_item item;
        item.track = trk;
        item.final_req = fin;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data <= item;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
        accept_request(item);
        burst_left--;
        if (burst_left <= 0) begin
            pause_input($urandom_range(1, 10));
            burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
        end
    endtask

    task automatic send_batch(int count);
        cluster_base = TRACK_BITS'($urandom);
        for (int i = 0; i < count; i++)
            send_request(pick_track(), i == count - 1);
    endtask

    // Lets every queued seek arrive and the block settle before anything else.
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_seeks.size() != 0) @(posedge i_clk);
        repeat (PICK_CYCLES + 4) @(posedge i_clk);
    endtask

    task automatic write_start_track(logic [TRACK_BITS-1:0] value);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        start_track_reg = value;
        start_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_start_track();
        send_request(16'd100, 1'b0);
        send_request(16'd15, 1'b1);
        send_request(16'd65535, 1'b1);
    endtask

    task automatic test_tie_break();
        write_start_track(16'd1000);
        send_request(16'd1010, 1'b0);
        send_request(16'd990, 1'b0);
        send_request(16'd1010, 1'b0);
        send_request(16'd995, 1'b0);
        send_request(16'd1005, 1'b1);
    endtask

    task automatic test_track_extremes();
        write_start_track(16'd0);
        send_request(16'd65535, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd32768, 1'b1);
        write_start_track(16'd65535);
        send_request(16'd0, 1'b0);
        send_request(16'd65535, 1'b0);
        send_request(16'd21845, 1'b0);
        send_request(16'd43690, 1'b1);
        send_request(16'd0, 1'b1);
    endtask

    task automatic test_table_overflow();
        write_start_track(TRACK_BITS'($urandom));
        send_batch(TABLE_DEPTH + 2);
        // The closing transaction itself is dropped, yet the stored requests are served.
        send_batch(TABLE_DEPTH + 1);
        send_batch(TABLE_DEPTH);
    endtask

    task automatic test_output_hold_off();
        wait_idle();
        hold_request = 1500;
        for (int b = 0; b < 3; b++)
            send_batch(6);
    endtask

    task automatic test_random_batches();
        int size_pick;
        int batch_no;
        batch_no = 0;
        while (requests_sent < ITEM_TARGET) begin
            if (batch_no % 8 == 7) begin
                case ($urandom_range(0, 3))
                    0: write_start_track('0);
                    1: write_start_track('1);
                    default: write_start_track(TRACK_BITS'($urandom));
                endcase
            end
            size_pick = $urandom_range(0, 19);
            if (size_pick == 0)
                send_batch($urandom_range(TABLE_DEPTH, TABLE_DEPTH + 3));
            else if (size_pick < 4)
                send_batch($urandom_range(9, TABLE_DEPTH - 1));
            else
                send_batch($urandom_range(1, 8));
            batch_no++;
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_start_track();
        test_tie_break();
        test_track_extremes();
        test_table_overflow();
        test_output_hold_off();
        test_random_batches();
        write_start_track(START_RESET);
        send_batch(5);
        wait_idle();
        repeat (2 * PICK_CYCLES) @(posedge i_clk);
        if (expected_seeks.size() != 0)
            mismatch_count++;
        $display("covered %0d requests in %0d batches (%0d with drops), %0d seeks checked",
                 requests_sent, batches_closed, dropped_batches, seeks_checked);
        $display("start track written %0d times, %0d mismatches, %0d cycles",
                 start_writes, mismatch_count, cycle_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/sstf_pkg.sv
rtl/sstf_cell.sv
rtl/shortest_seek_first_scheduler.sv
tb/shortest_seek_first_scheduler_tb.sv
